FILE: rtl/core/prim_maze_generator_core_defines.svh
// Assertion macros for the maze generator RTL
`ifndef PRIM_MAZE_GENERATOR_CORE_DEFINES_SVH
`define PRIM_MAZE_GENERATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PMG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("maze generator check failed");
`define PMG_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("maze generator reset check failed");
`else
`define PMG_ASSERT(lbl, prop)
`define PMG_ASSERT_RST(lbl, prop)
`endif
`endif

FILE: rtl/core/pmg_pkg.sv
// Types, constants and helpers for the maze generator
`timescale 1ns / 1ps
`default_nettype none
package pmg_pkg;

  localparam int MAZE_W         = 9;
  localparam int MAZE_H         = 9;
  localparam int LIST_DEPTH_DEF = 128;
  localparam int NCELLS         = MAZE_W * MAZE_H;
  localparam int CELL_AW        = $clog2(NCELLS);
  localparam int ROW_BITS       = 2 * MAZE_W;

  localparam logic [1:0] CELL_PATH   = 2'd0;
  localparam logic [1:0] CELL_WALL   = 2'd1;
  localparam logic [1:0] CELL_TARGET = 2'd2;

  localparam logic [2:0] KIND_STARTED   = 3'd0;
  localparam logic [2:0] KIND_CARVED    = 3'd1;
  localparam logic [2:0] KIND_DISCARDED = 3'd2;
  localparam logic [2:0] KIND_IDLE      = 3'd3;
  localparam logic [2:0] KIND_ROW       = 3'd4;

  localparam logic CFG_START_X = 1'b0;
  localparam logic CFG_START_Y = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [30:0] rand_value;
  } req_t;

  typedef struct packed {
    logic [2:0]          kind;
    logic [3:0]          row_index;
    logic [ROW_BITS-1:0] row_cells;
    logic [7:0]          pending_walls;
    logic                overflow;
    logic                last;
  } res_t;

  typedef struct packed {
    logic [3:0] x;
    logic [3:0] y;
    logic [1:0] dir;
  } wall_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD_START, OP_LOAD_DRAW, OP_FILL, OP_NB_RD, OP_NB_CHK, OP_NB_SKIP,
    OP_OPEN_START, OP_EMIT, OP_DIV, OP_E_RD, OP_E_CAP, OP_B_RD, OP_OPEN_E, OP_OPEN_B,
    OP_DISCARD, OP_S_RD, OP_S_WR, OP_DEC, OP_IDLE_EMIT, OP_TARGET, OP_R_RD, OP_R_ACC,
    OP_R_EMIT
  } dp_op_e;

  typedef struct packed {
    logic fill_last;
    logic nb_ok;
    logic d_last;
    logic div_last;
    logic b_ok;
    logic b_wall;
    logic shift_more;
    logic cnt_zero;
    logic gen;
    logic rx_last;
    logic ry_last;
  } dp_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FILL, ST_NB_RD, ST_NB_CHK, ST_OPEN_START, ST_EMIT, ST_DIV, ST_E_RD,
    ST_E_CAP, ST_B_RD, ST_B_CHK, ST_OPEN_B, ST_SHIFT, ST_S_WR, ST_IDLE_EMIT,
    ST_TARGET, ST_R_RD, ST_R_ACC, ST_R_EMIT
  } ctl_state_e;

  // one step in direction d: up, down, left, right
  function automatic logic signed [2:0] step_x(input logic [1:0] d);
    case (d)
      2'd2:    step_x = -3'sd1;
      2'd3:    step_x = 3'sd1;
      default: step_x = 3'sd0;
    endcase
  endfunction

  function automatic logic signed [2:0] step_y(input logic [1:0] d);
    case (d)
      2'd0:    step_y = -3'sd1;
      2'd1:    step_y = 3'sd1;
      default: step_y = 3'sd0;
    endcase
  endfunction

  function automatic logic signed [5:0] move(input logic [3:0] c,
                                             input logic signed [2:0] s);
    move = $signed({2'b00, c}) + 6'(s);
  endfunction

  function automatic logic in_x(input logic signed [5:0] v);
    in_x = (v >= 6'sd0) && (v < 6'(MAZE_W));
  endfunction

  function automatic logic in_y(input logic signed [5:0] v);
    in_y = (v >= 6'sd0) && (v < 6'(MAZE_H));
  endfunction

  function automatic logic [CELL_AW-1:0] cell_addr(input logic [3:0] x,
                                                   input logic [3:0] y);
    cell_addr = CELL_AW'(int'(y) * MAZE_W + int'(x));
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/prim_maze_generator_core.sv
// Randomized Prim maze generator, top level
//
// Command channel: a word on req_i is taken when start_i is high and busy_o
// low. req_type 0 starts a maze, 1 brings one random draw.
// Config channel: cfg_index_i 0 sets start_x, 1 sets start_y; cfg_ready_o is
// always high. Write only while idle.
// Results: each word sits on res_o for one cycle with res_valid_o high; the
// receiver cannot stall, and last marks the final word of a command.
// Sequence: a start fills the cell map with walls, then checks each in-range
// neighbour of the start cell. A draw runs the bit-serial remainder unit, then
// the pick, carve and listing, then the order-keeping removal that moves later
// list entries up. When the list empties, a map dump reads every cell and
// emits one word per row.
// Reset: map contents are undefined until the next start; list empty, not
// generating, overflow clear, start cell (1,1).
`timescale 1ns / 1ps
`default_nettype none
`include "prim_maze_generator_core_defines.svh"
module prim_maze_generator_core #(
  parameter int LIST_DEPTH = pmg_pkg::LIST_DEPTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire pmg_pkg::req_t req_i,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [0:0]    cfg_index_i,
  input  wire logic [3:0]    cfg_data_i,
  output logic               res_valid_o,
  output pmg_pkg::res_t      res_o
);
  import pmg_pkg::*;

  dp_op_e   op;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  pmg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_i.req_type),
    .stat_i     (stat),
    .op_o       (op),
    .busy_o     (busy_o)
  );

  pmg_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .stat_o      (stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  `PMG_ASSERT(a_accept_busy, (start_i && !busy_o) |=> busy_o)
  `PMG_ASSERT(a_last_row, (res_valid_o && res_o.kind == KIND_ROW && res_o.last) |-> (res_o.row_index == 4'(MAZE_H - 1)))
  `PMG_ASSERT(a_idle_last, (res_valid_o && res_o.kind == KIND_IDLE) |-> res_o.last)
  `PMG_ASSERT_RST(a_reset_idle, $rose(rst_ni) |-> !busy_o)

endmodule
`default_nettype wire

FILE: rtl/core/pmg_datapath.sv
// Maze generator datapath: cell map, wall list, remainder unit, result register
`timescale 1ns / 1ps
`default_nettype none
module pmg_datapath #(
  parameter int LIST_DEPTH = pmg_pkg::LIST_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire pmg_pkg::dp_op_e  op_i,
  input  wire pmg_pkg::req_t    req_i,
  input  wire logic             cfg_valid_i,
  input  wire logic [0:0]       cfg_index_i,
  input  wire logic [3:0]       cfg_data_i,
  output pmg_pkg::dp_stat_t     stat_o,
  output logic                  res_valid_o,
  output pmg_pkg::res_t         res_o
);
  import pmg_pkg::*;

  localparam int IDX_W = $clog2(LIST_DEPTH);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  logic [3:0] start_x_q, start_y_q;
  logic [3:0] cx_q, cy_q, rx_q, ry_q;
  logic [1:0] d_q;
  logic [CNT_W-1:0] cnt_q, rem_q;
  logic ovf_q, gen_q;
  logic [30:0] rnd_q;
  logic [4:0] bit_q;
  logic [IDX_W-1:0] ptr_q;
  wall_t e_q;
  logic [2:0] kind_q;
  logic [CELL_AW-1:0] fill_q;
  logic [ROW_BITS-1:0] row_q;
  logic res_valid_q;
  res_t res_q;
  res_t res_d;

  logic [1:0] cell_mem [NCELLS];
  logic [1:0] cell_rd_q;
  wall_t list_mem [LIST_DEPTH];
  wall_t list_rd_q;

  logic signed [5:0] nx, ny, fx, fy, bx, by;
  logic nb_ok, b_ok, shift_more;
  logic [CNT_W:0] rem_sh;
  logic [CNT_W-1:0] rem_next, ptr1;
  logic [3:0] sx, sy;
  logic [CNT_W+7:0] cnt_ext;

  logic cell_we, cell_re, list_we, list_re;
  logic [CELL_AW-1:0] cell_wa, cell_ra;
  logic [1:0] cell_wd;
  logic [IDX_W-1:0] list_wa, list_ra;
  wall_t list_wd;

  always_comb begin
    nx = move(cx_q, step_x(d_q));
    ny = move(cy_q, step_y(d_q));
    fx = move(cx_q, 3'(2 * step_x(d_q)));
    fy = move(cy_q, 3'(2 * step_y(d_q)));
    nb_ok = in_x(nx) && in_y(ny) && in_x(fx) && in_y(fy);
    bx = move(e_q.x, step_x(e_q.dir));
    by = move(e_q.y, step_y(e_q.dir));
    b_ok = in_x(bx) && in_y(by) && (e_q.x < 4'(MAZE_W)) && (e_q.y < 4'(MAZE_H));
    // one restoring step of the remainder per cycle
    rem_sh = {rem_q, rnd_q[30]};
    rem_next = (rem_sh >= {1'b0, cnt_q}) ? CNT_W'(rem_sh - {1'b0, cnt_q})
                                         : rem_sh[CNT_W-1:0];
    ptr1 = CNT_W'(ptr_q) + CNT_W'(1);
    shift_more = ptr1 < cnt_q;
    sx = (start_x_q >= 4'(MAZE_W)) ? 4'(MAZE_W - 1) : start_x_q;
    sy = (start_y_q >= 4'(MAZE_H)) ? 4'(MAZE_H - 1) : start_y_q;
    cnt_ext = {8'd0, cnt_q};
  end

  always_comb begin
    stat_o.fill_last  = fill_q == CELL_AW'(NCELLS - 1);
    stat_o.nb_ok      = nb_ok;
    stat_o.d_last     = d_q == 2'd3;
    stat_o.div_last   = bit_q == 5'd0;
    stat_o.b_ok       = b_ok;
    stat_o.b_wall     = cell_rd_q == CELL_WALL;
    stat_o.shift_more = shift_more;
    stat_o.cnt_zero   = cnt_q == '0;
    stat_o.gen        = gen_q;
    stat_o.rx_last    = rx_q == 4'(MAZE_W - 1);
    stat_o.ry_last    = ry_q == 4'(MAZE_H - 1);
  end

  // memory port steering
  always_comb begin
    cell_we = 1'b0;
    cell_wa = cell_addr(cx_q, cy_q);
    cell_wd = CELL_PATH;
    cell_re = 1'b0;
    cell_ra = cell_addr(nx[3:0], ny[3:0]);
    list_we = 1'b0;
    list_wa = cnt_q[IDX_W-1:0];
    list_wd = '{x: nx[3:0], y: ny[3:0], dir: d_q};
    list_re = 1'b0;
    list_ra = rem_q[IDX_W-1:0];
    case (op_i)
      OP_FILL: begin
        cell_we = 1'b1;
        cell_wa = fill_q;
        cell_wd = CELL_WALL;
      end
      OP_NB_RD: cell_re = 1'b1;
      OP_NB_CHK: list_we = (cell_rd_q == CELL_WALL) && (cnt_q < CNT_W'(LIST_DEPTH));
      OP_OPEN_START: cell_we = 1'b1;
      OP_E_RD: list_re = 1'b1;
      OP_B_RD: begin
        cell_re = 1'b1;
        cell_ra = cell_addr(bx[3:0], by[3:0]);
      end
      OP_OPEN_E: begin
        cell_we = 1'b1;
        cell_wa = cell_addr(e_q.x, e_q.y);
      end
      OP_OPEN_B: begin
        cell_we = 1'b1;
        cell_wa = cell_addr(bx[3:0], by[3:0]);
      end
      OP_S_RD: begin
        list_re = 1'b1;
        list_ra = ptr1[IDX_W-1:0];
      end
      OP_S_WR: begin
        list_we = 1'b1;
        list_wa = ptr_q;
        list_wd = list_rd_q;
      end
      OP_TARGET: begin
        cell_we = 1'b1;
        cell_wa = cell_addr(4'(MAZE_W - 2), 4'(MAZE_H - 2));
        cell_wd = CELL_TARGET;
      end
      OP_R_RD: begin
        cell_re = 1'b1;
        cell_ra = cell_addr(rx_q, ry_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) cell_mem[cell_wa] <= cell_wd;
    if (cell_re) cell_rd_q <= cell_mem[cell_ra];
    if (list_we) list_mem[list_wa] <= list_wd;
    if (list_re) list_rd_q <= list_mem[list_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= 4'd1;
      start_y_q <= 4'd1;
      cnt_q     <= '0;
      gen_q     <= 1'b0;
      ovf_q     <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_index_i == CFG_START_X) start_x_q <= cfg_data_i;
      if (cfg_valid_i && cfg_index_i == CFG_START_Y) start_y_q <= cfg_data_i;
      case (op_i)
        OP_LOAD_START: begin
          cnt_q <= '0;
          ovf_q <= 1'b0;
          gen_q <= 1'b1;
        end
        OP_NB_CHK: begin
          if (cell_rd_q == CELL_WALL) begin
            if (cnt_q < CNT_W'(LIST_DEPTH)) cnt_q <= cnt_q + CNT_W'(1);
            else ovf_q <= 1'b1;
          end
        end
        OP_DEC:    cnt_q <= cnt_q - CNT_W'(1);
        OP_TARGET: gen_q <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD_START: begin
        cx_q   <= sx;
        cy_q   <= sy;
        d_q    <= 2'd0;
        fill_q <= '0;
        kind_q <= KIND_STARTED;
      end
      OP_LOAD_DRAW: begin
        rnd_q <= req_i.rand_value;
        rem_q <= '0;
        bit_q <= 5'd30;
      end
      OP_FILL:    fill_q <= fill_q + CELL_AW'(1);
      OP_NB_CHK,
      OP_NB_SKIP: d_q <= d_q + 2'd1;
      OP_DIV: begin
        rem_q <= rem_next;
        rnd_q <= {rnd_q[29:0], 1'b0};
        bit_q <= bit_q - 5'd1;
      end
      OP_E_RD:  ptr_q <= rem_q[IDX_W-1:0];
      OP_E_CAP: e_q <= list_rd_q;
      OP_OPEN_B: begin
        cx_q   <= bx[3:0];
        cy_q   <= by[3:0];
        d_q    <= 2'd0;
        kind_q <= KIND_CARVED;
      end
      OP_DISCARD: kind_q <= KIND_DISCARDED;
      OP_S_WR:    ptr_q <= ptr1[IDX_W-1:0];
      OP_TARGET: begin
        rx_q <= 4'd0;
        ry_q <= 4'd0;
      end
      OP_R_ACC: begin
        row_q <= {cell_rd_q, row_q[ROW_BITS-1:2]};
        rx_q  <= rx_q + 4'd1;
      end
      OP_R_EMIT: begin
        rx_q <= 4'd0;
        ry_q <= ry_q + 4'd1;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (op_i == OP_EMIT) || (op_i == OP_IDLE_EMIT) || (op_i == OP_R_EMIT);
    end
  end

  always_comb begin
    res_d.kind          = KIND_IDLE;
    res_d.row_index     = 4'd0;
    res_d.row_cells     = '0;
    res_d.pending_walls = cnt_ext[7:0];
    res_d.overflow      = ovf_q;
    res_d.last          = 1'b1;
    case (op_i)
      OP_EMIT: begin
        res_d.kind = kind_q;
        res_d.last = cnt_q != '0;
      end
      OP_R_EMIT: begin
        res_d.kind      = KIND_ROW;
        res_d.row_index = ry_q;
        res_d.row_cells = row_q;
        res_d.last      = ry_q == 4'(MAZE_H - 1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

FILE: rtl/core/pmg_ctrl.sv
// Maze generator sequencer: steps the datapath through start, draw and map dump
`timescale 1ns / 1ps
`default_nettype none
module pmg_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              req_type_i,
  input  wire pmg_pkg::dp_stat_t stat_i,
  output pmg_pkg::dp_op_e        op_o,
  output logic                   busy_o
);
  import pmg_pkg::*;

  ctl_state_e state_q, state_d;
  logic draw_q, draw_d;
  ctl_state_e after_list;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      draw_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      draw_q  <= draw_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    draw_d     = draw_q;
    op_o       = OP_NONE;
    after_list = draw_q ? ST_SHIFT : ST_OPEN_START;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          draw_d = req_type_i;
          if (req_type_i) begin
            op_o    = OP_LOAD_DRAW;
            state_d = (!stat_i.gen || stat_i.cnt_zero) ? ST_IDLE_EMIT : ST_DIV;
          end else begin
            op_o    = OP_LOAD_START;
            state_d = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        op_o = OP_FILL;
        if (stat_i.fill_last) state_d = ST_NB_RD;
      end
      ST_NB_RD: begin
        if (stat_i.nb_ok) begin
          op_o    = OP_NB_RD;
          state_d = ST_NB_CHK;
        end else begin
          op_o = OP_NB_SKIP;
          if (stat_i.d_last) state_d = after_list;
        end
      end
      ST_NB_CHK: begin
        op_o    = OP_NB_CHK;
        state_d = stat_i.d_last ? after_list : ST_NB_RD;
      end
      ST_OPEN_START: begin
        op_o    = OP_OPEN_START;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        op_o    = OP_EMIT;
        state_d = stat_i.cnt_zero ? ST_TARGET : ST_IDLE;
      end
      ST_DIV: begin
        op_o = OP_DIV;
        if (stat_i.div_last) state_d = ST_E_RD;
      end
      ST_E_RD: begin
        op_o    = OP_E_RD;
        state_d = ST_E_CAP;
      end
      ST_E_CAP: begin
        op_o    = OP_E_CAP;
        state_d = ST_B_RD;
      end
      ST_B_RD: begin
        if (stat_i.b_ok) begin
          op_o    = OP_B_RD;
          state_d = ST_B_CHK;
        end else begin
          op_o    = OP_DISCARD;
          state_d = ST_SHIFT;
        end
      end
      ST_B_CHK: begin
        if (stat_i.b_wall) begin
          op_o    = OP_OPEN_E;
          state_d = ST_OPEN_B;
        end else begin
          op_o    = OP_DISCARD;
          state_d = ST_SHIFT;
        end
      end
      ST_OPEN_B: begin
        op_o    = OP_OPEN_B;
        state_d = ST_NB_RD;
      end
      ST_SHIFT: begin
        if (stat_i.shift_more) begin
          op_o    = OP_S_RD;
          state_d = ST_S_WR;
        end else begin
          op_o    = OP_DEC;
          state_d = ST_EMIT;
        end
      end
      ST_S_WR: begin
        op_o    = OP_S_WR;
        state_d = ST_SHIFT;
      end
      ST_IDLE_EMIT: begin
        op_o    = OP_IDLE_EMIT;
        state_d = ST_IDLE;
      end
      ST_TARGET: begin
        op_o    = OP_TARGET;
        state_d = ST_R_RD;
      end
      ST_R_RD: begin
        op_o    = OP_R_RD;
        state_d = ST_R_ACC;
      end
      ST_R_ACC: begin
        op_o    = OP_R_ACC;
        state_d = stat_i.rx_last ? ST_R_EMIT : ST_R_RD;
      end
      ST_R_EMIT: begin
        op_o    = OP_R_EMIT;
        state_d = stat_i.ry_last ? ST_IDLE : ST_R_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = state_q != ST_IDLE;

endmodule
`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for the maze generator core: directed table, then random mazes
`timescale 1ns / 1ps
module testbench;
  import pmg_pkg::*;

  localparam int LIMIT  = 1_500_000;
  localparam int SETTLE = 600;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  req_t req_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [0:0] cfg_index_i = '0;
  logic [3:0] cfg_data_i = '0;
  logic res_valid_o;
  res_t res_o;

  prim_maze_generator_core i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i, .cfg_data_i, .res_valid_o, .res_o
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [1:0] grid [MAZE_H][MAZE_W];
  wall_t      frontier_q [$];
  bit         carving;
  bit         lost_push;
  int         cell_x = 1, cell_y = 1;
  res_t       maze_words_q [$];
  int         fails;
  int         cycles;
  int         sender_gap_pct;

  const int dx1 [4] = '{0, 0, -1, 1};
  const int dy1 [4] = '{-1, 1, 0, 0};

  function automatic bit off_grid(int x, int y);
    return x < 0 || x >= MAZE_W || y < 0 || y >= MAZE_H;
  endfunction

  function automatic void list_walls(int x, int y);
    wall_t w;
    for (int d = 0; d < 4; d++) begin
      if (off_grid(x + dx1[d], y + dy1[d]) || off_grid(x + 2 * dx1[d], y + 2 * dy1[d]))
        continue;
      if (grid[y + dy1[d]][x + dx1[d]] != CELL_WALL) continue;
      if (frontier_q.size() >= LIST_DEPTH_DEF) begin
        lost_push = 1'b1;
        continue;
      end
      w.x = 4'(x + dx1[d]);
      w.y = 4'(y + dy1[d]);
      w.dir = 2'(d);
      frontier_q = {frontier_q, w};
    end
  endfunction

  function automatic void add_word(logic [2:0] kind, int row, logic [ROW_BITS-1:0] cells,
                                   bit last);
    res_t r;
    r.kind = kind;
    r.row_index = 4'(row);
    r.row_cells = cells;
    r.pending_walls = 8'(frontier_q.size());
    r.overflow = lost_push;
    r.last = last;
    maze_words_q = {maze_words_q, r};
  endfunction

  function automatic void dump_map(logic [2:0] kind);
    logic [ROW_BITS-1:0] cells;
    add_word(kind, 0, '0, 1'b0);
    grid[MAZE_H-2][MAZE_W-2] = CELL_TARGET;
    carving = 1'b0;
    for (int y = 0; y < MAZE_H; y++) begin
      cells = '0;
      for (int x = 0; x < MAZE_W; x++) cells[2*x +: 2] = grid[y][x];
      add_word(KIND_ROW, y, cells, y == MAZE_H - 1);
    end
  endfunction

  function automatic void predict_maze(req_t r);
    int sx, sy, idx, bx, by;
    wall_t e;
    logic [2:0] kind;
    if (r.req_type == 1'b0) begin
      sx = cell_x >= MAZE_W ? MAZE_W - 1 : cell_x;
      sy = cell_y >= MAZE_H ? MAZE_H - 1 : cell_y;
      foreach (grid[y, x]) grid[y][x] = CELL_WALL;
      frontier_q.delete();
      lost_push = 1'b0;
      carving = 1'b1;
      list_walls(sx, sy);
      grid[sy][sx] = CELL_PATH;
      if (frontier_q.size() == 0) dump_map(KIND_STARTED);
      else add_word(KIND_STARTED, 0, '0, 1'b1);
    end else if (!carving || frontier_q.size() == 0) begin
      add_word(KIND_IDLE, 0, '0, 1'b1);
    end else begin
      idx = int'(r.rand_value % 31'(frontier_q.size()));
      e = frontier_q[idx];
      bx = int'(e.x) + dx1[e.dir];
      by = int'(e.y) + dy1[e.dir];
      kind = KIND_DISCARDED;
      if (!off_grid(bx, by) && !off_grid(e.x, e.y) && grid[by][bx] == CELL_WALL) begin
        grid[e.y][e.x] = CELL_PATH;
        grid[by][bx] = CELL_PATH;
        list_walls(bx, by);
        kind = KIND_CARVED;
      end
      frontier_q.delete(idx);
      if (frontier_q.size() == 0) dump_map(kind);
      else add_word(kind, 0, '0, 1'b1);
    end
  endfunction

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin
    res_t e;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("prim_maze_generator_core regression: fail");
      $finish;
    end else if (rst_ni && res_valid_o) begin
      if (maze_words_q.size() == 0) begin
        $error("unexpected result word, kind %0d", res_o.kind);
        fails++;
      end else begin
        e = maze_words_q.pop_front();
        check_field("kind", e.kind, res_o.kind);
        check_field("row_index", e.row_index, res_o.row_index);
        check_field("row_cells", e.row_cells, res_o.row_cells);
        check_field("pending_walls", e.pending_walls, res_o.pending_walls);
        check_field("overflow", e.overflow, res_o.overflow);
        check_field("last", e.last, res_o.last);
      end
    end
  end

  // all tasks below are entered and left at a falling edge
  task automatic send(bit req, logic [30:0] rnd);
    req_t r;
    r.req_type = req;
    r.rand_value = rnd;
    start_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy_o);
    predict_maze(r);
    @(negedge clk_i);
  endtask

  task automatic maybe_gap();
    if ($urandom_range(0, 99) < sender_gap_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    do @(negedge clk_i); while (maze_words_q.size() != 0);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [3:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_START_X) cell_x = val;
    else cell_y = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  typedef struct {
    bit         req;
    logic [30:0] rnd;
    bit         typed;
    logic [2:0] kind;
  } stim_row_t;

  stim_row_t plan [] = '{
    '{1'b1, 31'h0,        1'b1, KIND_IDLE},
    '{1'b1, 31'h7fffffff, 1'b1, KIND_IDLE},
    '{1'b0, 31'h0,        1'b1, KIND_STARTED},
    '{1'b1, 31'h0,        1'b0, KIND_IDLE},
    '{1'b1, 31'h7fffffff, 1'b0, KIND_IDLE},
    '{1'b1, 31'h55555555, 1'b0, KIND_IDLE},
    '{1'b1, 31'h2aaaaaaa, 1'b0, KIND_IDLE},
    '{1'b1, 31'h1,        1'b0, KIND_IDLE},
    '{1'b1, 31'h3,        1'b0, KIND_IDLE},
    '{1'b0, 31'h7fffffff, 1'b1, KIND_STARTED},
    '{1'b1, 31'h40000000, 1'b0, KIND_IDLE},
    '{1'b1, 31'h0,        1'b0, KIND_IDLE},
    '{1'b1, 31'h0,        1'b0, KIND_IDLE},
    '{1'b1, 31'h7ffffffe, 1'b0, KIND_IDLE}
  };

  // start cells: default, corners, out of range (saturates), odd spots
  int xs [6] = '{0, 8, 15, 4, 0, 1};
  int ys [6] = '{0, 8, 15, 2, 8, 1};

  initial begin
    int budget;
    foreach (grid[y, x]) grid[y][x] = CELL_WALL;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    sender_gap_pct = 0;
    foreach (plan[i]) begin
      send(plan[i].req, plan[i].rnd);
      if (plan[i].typed) maze_words_q[$].kind = plan[i].kind;
    end

    for (int s = 0; s < 6; s++) begin
      drain();
      repeat (SETTLE) @(negedge clk_i);
      write_reg(CFG_START_X, 4'(xs[s]));
      write_reg(CFG_START_Y, 4'(ys[s]));
      case (s % 4)
        0: sender_gap_pct = 0;
        1: sender_gap_pct = 47;
        2: sender_gap_pct = 0;
        default: sender_gap_pct = 31;
      endcase
      budget = 60;
      send(1'b0, 31'($urandom()));
      while (budget > 0) begin
        maybe_gap();
        if (budget == 30) drain();
        if ($urandom_range(0, 99) < 4) send(1'b0, 31'($urandom()));
        else if (!carving) begin
          if ($urandom_range(0, 3) == 0) send(1'b1, 31'($urandom()));
          else send(1'b0, 31'($urandom()));
        end else if ($urandom_range(0, 1) == 0) send(1'b1, 31'($urandom_range(0, 300)));
        else send(1'b1, 31'($urandom()));
        budget--;
      end
    end

    drain();
    repeat (SETTLE) @(negedge clk_i);
    if (fails == 0) $display("prim_maze_generator_core regression: pass");
    else $display("prim_maze_generator_core regression: fail");
    $finish;
  end
endmodule
